>>> hw/rtl/windowed_crest_factor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed crest factor block
// Shared property forms, clocked on the rising edge with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_CREST_FACTOR_ASSERT_SVH
`define WINDOWED_CREST_FACTOR_ASSERT_SVH

// Same-cycle implication.
`define WCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wcf_pkg.sv
// ----------------------------------------------------------------------------
// wcf_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wcf_pkg;

  localparam int DefMaxWindow  = 1024;
  localparam int DefSampleBits = 24;

  localparam int LenW     = 11;
  localparam int LenReset = 1024;

  localparam int CrestW    = 23;
  localparam int CrestFrac = 12;
  localparam logic [CrestW-1:0] CrestOne = CrestW'(4096);
  localparam logic [CrestW-1:0] CrestMax = {CrestW{1'b1}};

  localparam int DivCntW = $clog2(CrestW);

  typedef struct packed {
    logic cfg_wr;
    logic accept;
    logic scan_rd;
    logic mul;
    logic prep;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic skip_div;
    logic div_last;
  } status_t;

endpackage

>>> hw/rtl/wcf_ctrl.sv
// ----------------------------------------------------------------------------
// wcf_ctrl
// Sequencer: accept, window scan, multiply, serial divide, result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             gate_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  output wcf_pkg::cmd_t    cmd_o,
  input  wcf_pkg::status_t status_i
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StMul,
    StPrep,
    StDiv,
    StOut
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        // an offered input beat wins over a config write in the same cycle
        cmd_o.cfg_wr = cfg_valid_i && !in_valid_i;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = gate_i ? StScan : StOut;
        end
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StPrep;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.skip_div ? StOut : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StOut;
        end
      end
      StOut: begin
        // output register must be free or draining this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !in_valid_i;
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/wcf_datapath.sv
// ----------------------------------------------------------------------------
// wcf_datapath
// Magnitude ring memory, scan accumulators, multiplier and serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcf_datapath #(
  parameter int MAX_WINDOW  = wcf_pkg::DefMaxWindow,
  parameter int SAMPLE_BITS = wcf_pkg::DefSampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic [wcf_pkg::LenW-1:0]     cfg_window_length_i,
  input  wcf_pkg::cmd_t                cmd_i,
  output wcf_pkg::status_t             status_o,
  output logic [wcf_pkg::CrestW-1:0]   crest_o,
  output logic                         silent_window_o
);

  localparam int AddrW = $clog2(MAX_WINDOW);
  localparam int CntW  = $clog2(MAX_WINDOW + 1);
  localparam int SumW  = SAMPLE_BITS + CntW;
  localparam int ProdW = CntW + SAMPLE_BITS;
  localparam int NumW  = ProdW + wcf_pkg::CrestFrac;
  localparam int CW    = wcf_pkg::CrestW;
  localparam int LenResetEff =
    (wcf_pkg::LenReset > MAX_WINDOW) ? MAX_WINDOW : wcf_pkg::LenReset;

  logic [SAMPLE_BITS-1:0] mem_q [MAX_WINDOW];

  logic [CntW-1:0]        len_q;
  logic [AddrW-1:0]       pos_q;
  logic                   filled_q;
  logic [CW-1:0]          held_q;
  logic                   rd_valid_q;

  logic [CntW-1:0]        count_q;
  logic [AddrW-1:0]       idx_q;
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [SumW-1:0]        sum_q;
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [ProdW-1:0]       prod_q;
  logic [NumW-1:0]        rem_q;
  logic [CW-1:0]          quo_q;
  logic [wcf_pkg::DivCntW-1:0] div_cnt_q;
  logic                   silent_res_q;
  logic [CW-1:0]          crest_q;
  logic                   silent_q;

  logic [SAMPLE_BITS-1:0] mag;
  logic [CntW-1:0]        pos_inc;
  logic                   wrap;
  logic [CntW-1:0]        len_new;
  logic [NumW-1:0]        num;
  logic [NumW-1:0]        rem_init;
  logic [NumW-1:0]        sum_ext;
  logic                   sum_zero;
  logic                   ovf;
  logic [NumW-1:0]        rem_sh;
  logic                   q_bit;

  // two's complement magnitude; the most negative code maps to 2^(N-1)
  assign mag = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;

  assign pos_inc = CntW'(pos_q) + 1'b1;
  assign wrap    = (pos_inc == len_q);

  always_comb begin
    if (cfg_window_length_i == '0) begin
      len_new = CntW'(1);
    end else if (32'(cfg_window_length_i) > 32'(MAX_WINDOW)) begin
      len_new = CntW'(MAX_WINDOW);
    end else begin
      len_new = CntW'(cfg_window_length_i);
    end
  end

  assign num      = {prod_q, {wcf_pkg::CrestFrac{1'b0}}};
  assign rem_init = num >> CW;
  assign sum_ext  = NumW'(sum_q);
  assign sum_zero = (sum_q == '0);
  // quotient fits in CW bits only if num >> CW is below the divisor
  assign ovf      = (rem_init >= sum_ext);
  assign rem_sh   = {rem_q[NumW-2:0], quo_q[CW-1]};
  assign q_bit    = (rem_sh >= sum_ext);

  assign status_o.scan_last = ((CntW'(idx_q) + 1'b1) == count_q);
  assign status_o.skip_div  = sum_zero || ovf;
  assign status_o.div_last  = (div_cnt_q == wcf_pkg::DivCntW'(CW - 1));

  // ring memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[pos_q] <= mag;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= CntW'(LenResetEff);
      pos_q      <= '0;
      filled_q   <= 1'b0;
      held_q     <= wcf_pkg::CrestOne;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_rd;
      if (cmd_i.cfg_wr) begin
        len_q    <= len_new;
        pos_q    <= '0;
        filled_q <= 1'b0;
      end else if (cmd_i.accept) begin
        pos_q <= wrap ? '0 : pos_q + 1'b1;
        if (wrap) begin
          filled_q <= 1'b1;
        end
      end
      if (cmd_i.prep) begin
        if (sum_zero) begin
          held_q <= '0;
        end else if (ovf) begin
          held_q <= wcf_pkg::CrestMax;
        end
      end
      if (cmd_i.div_step && status_o.div_last) begin
        held_q <= {quo_q[CW-2:0], q_bit};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      count_q      <= (filled_q || wrap) ? len_q : pos_inc;
      idx_q        <= '0;
      sum_q        <= '0;
      peak_q       <= '0;
      silent_res_q <= 1'b0;
    end else begin
      if (cmd_i.scan_rd) begin
        idx_q <= idx_q + 1'b1;
      end
      if (rd_valid_q) begin
        sum_q <= sum_q + SumW'(rd_data_q);
        if (rd_data_q > peak_q) begin
          peak_q <= rd_data_q;
        end
      end
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(count_q) * ProdW'(peak_q);
    end
    if (cmd_i.prep) begin
      rem_q     <= rem_init;
      quo_q     <= CW'(num);
      div_cnt_q <= '0;
      if (sum_zero) begin
        silent_res_q <= 1'b1;
      end
    end
    // restoring division, one quotient bit per cycle
    if (cmd_i.div_step) begin
      rem_q     <= q_bit ? (rem_sh - sum_ext) : rem_sh;
      quo_q     <= {quo_q[CW-2:0], q_bit};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      crest_q  <= held_q;
      silent_q <= silent_res_q;
    end
  end

  assign crest_o         = crest_q;
  assign silent_window_o = silent_q;

endmodule

>>> hw/rtl/windowed_crest_factor.sv
// ----------------------------------------------------------------------------
// windowed_crest_factor
// Crest factor (peak * count / sum) over a ring window of sample magnitudes.
// ----------------------------------------------------------------------------
// Input channel: sample_i and gate_i move as one beat when in_valid_i is high
// and in_stall_o is low. Every beat writes the sample magnitude into the ring
// and yields exactly one output beat (crest_o, silent_window_o), handed over
// when out_valid_o is high and out_stall_i is low.
// With gate_i low the held crest is repeated.
// With gate_i high the filled entries are read one per cycle from the ring
// memory port, then one multiply and a 23-step restoring divide follow; the
// divide is skipped when the sum is zero or the quotient would overflow.
// The output register decouples the sides: a new beat is taken while the last
// result waits; a stalled receiver holds the next result in the sequencer.
// cfg_window_length_i is taken when cfg_valid_i and cfg_ready_o are high
// (block idle, no input beat offered) and restarts the window.
// Reset: window length 1024, empty window, held crest 1.0 (4096). The ring
// memory needs no clearing pass; only entries written since restart are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_crest_factor_assert.svh"

module windowed_crest_factor #(
  parameter int MAX_WINDOW  = wcf_pkg::DefMaxWindow,
  parameter int SAMPLE_BITS = wcf_pkg::DefSampleBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  input  logic                       gate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wcf_pkg::CrestW-1:0] crest_o,
  output logic                       silent_window_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [wcf_pkg::LenW-1:0]   cfg_window_length_i
);

  wcf_pkg::cmd_t    cmd;
  wcf_pkg::status_t status;

  wcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .gate_i      (gate_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  wcf_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sample_i            (sample_i),
    .cfg_window_length_i (cfg_window_length_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .crest_o             (crest_o),
    .silent_window_o     (silent_window_o)
  );

  `WCF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "block idle right after accepting a beat")
  `WCF_ASSERT_NOW(a_silent_zero_crest, clk_i, rst_ni, out_valid_o && silent_window_o, crest_o == '0, "silent window with nonzero crest")
  `WCF_ASSERT_NOW(a_cfg_only_idle, clk_i, rst_ni, cfg_ready_o, !in_stall_o && !cmd.scan_rd && !cmd.div_step, "config open while busy")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for windowed_crest_factor. Samples and gate bits are fed
// on the input channel. A local ring-window model predicts crest and silent
// flag for every beat, and each output beat is checked in order against it.
// The run covers window lengths from 0 through 2047, a saturated 1024-entry
// window, random traffic under four idle mixes, and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int SampleW     = wcf_pkg::DefSampleBits;
  localparam int MaxWin      = wcf_pkg::DefMaxWindow;
  localparam int CrestW      = wcf_pkg::CrestW;
  localparam int LenW        = wcf_pkg::LenW;
  localparam int LenReset    = wcf_pkg::LenReset;
  localparam logic [CrestW-1:0] CrestOne = wcf_pkg::CrestOne;
  localparam logic [CrestW-1:0] CrestMax = wcf_pkg::CrestMax;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 1100;
  localparam int CycleLimit  = 2_000_000;
  localparam int FullItems   = 260;
  localparam int LensPerMix  = 2;
  localparam int RandItems   = 30;

  typedef struct packed {
    logic [CrestW-1:0] crest;
    logic              silent;
  } crest_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [SampleW-1:0]   sample_i = '0;
  logic                 gate_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CrestW-1:0]    crest_o;
  logic                 silent_window_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [LenW-1:0]      cfg_window_length_i = '0;

  // window model
  logic [SampleW-1:0]   mag_ring [MaxWin];
  int unsigned          wr_pos;
  logic                 ring_full;
  logic [CrestW-1:0]    held_crest;
  logic [LenW-1:0]      win_len_q;

  crest_result_t        crest_due_q [$];
  int                   fail_count = 0;
  int                   sender_idle_pct = 0;
  int                   recv_stall_pct = 0;
  logic                 hold_req = 1'b0;
  int                   hold_left = 0;
  int                   cycle_count = 0;

  windowed_crest_factor i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_i            (sample_i),
    .gate_i              (gate_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .crest_o             (crest_o),
    .silent_window_o     (silent_window_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_window_length_i (cfg_window_length_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("windowed_crest_factor verification failed");
      $finish;
    end
  end

  // Receiver: random stall, or a long counted hold-off when requested.
  always @(posedge clk_i) begin : recv_stall_p
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : crest_check_p
    crest_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (crest_due_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected beat: crest %0d silent %0b", crest_o, silent_window_o);
      end else begin
        want = crest_due_q.pop_front();
        if (crest_o !== want.crest || silent_window_o !== want.silent) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: crest exp %0d got %0d, silent exp %0b got %0b",
                     want.crest, crest_o, want.silent, silent_window_o);
        end
      end
    end
  end

  function automatic crest_result_t predict_crest(input logic [SampleW-1:0] s,
                                                  input logic g);
    crest_result_t   r;
    int unsigned     span;
    int unsigned     count;
    longint unsigned sum;
    longint unsigned peak;
    longint unsigned q;
    logic [SampleW-1:0] mag;
    span = (win_len_q == 0) ? 1 : ((win_len_q > MaxWin) ? MaxWin : win_len_q);
    if (wr_pos >= span) wr_pos = 0;
    // most negative sample maps onto itself, which is the exact magnitude
    mag = s[SampleW-1] ? (~s + 1'b1) : s;
    mag_ring[wr_pos] = mag;
    wr_pos++;
    if (wr_pos >= span) begin
      wr_pos = 0;
      ring_full = 1'b1;
    end
    r.silent = 1'b0;
    if (g) begin
      count = ring_full ? span : wr_pos;
      sum = 0;
      peak = 0;
      for (int i = 0; i < count; i++) begin
        sum += mag_ring[i];
        if (mag_ring[i] > peak) peak = mag_ring[i];
      end
      if (sum == 0) begin
        held_crest = '0;
        r.silent = 1'b1;
      end else begin
        q = (longint'(count) * peak * longint'(CrestOne)) / sum;
        held_crest = (q > CrestMax) ? CrestMax : q[CrestW-1:0];
      end
    end
    r.crest = held_crest;
    return r;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    logic [SampleW-1:0] s;
    case ($urandom_range(9))
      0, 1: s = '0;
      2: begin
        case ($urandom_range(3))
          0: s = {1'b0, {(SampleW-1){1'b1}}};
          1: s = {1'b1, {(SampleW-1){1'b0}}};
          2: s = '1;
          default: s = SampleW'(1);
        endcase
      end
      3, 4, 5: s = SampleW'($signed($urandom_range(510)) - 255);
      default: s = SampleW'($urandom);
    endcase
    return s;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_sample(input logic [SampleW-1:0] s, input logic g);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    gate_i     <= g;
    do @(posedge clk_i); while (in_stall_o);
    crest_due_q.push_back(predict_crest(s, g));
  endtask

  task automatic write_window_length(input logic [LenW-1:0] len);
    in_valid_i <= 1'b0;
    while (crest_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_window_length_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_len_q = len;
    wr_pos    = 0;
    ring_full = 1'b0;
  endtask

  task automatic test_reset_state();
    send_sample('0, 1'b0);
    send_sample({1'b0, {(SampleW-1){1'b1}}}, 1'b1);
    send_sample({1'b1, {(SampleW-1){1'b0}}}, 1'b1);
    send_sample(SampleW'(5), 1'b0);
  endtask

  // Length 0 behaves as 1; length 1 written as its own value.
  task automatic test_length_extremes();
    write_window_length('0);
    send_sample('0, 1'b1);
    send_sample(SampleW'(5), 1'b0);
    send_sample(SampleW'(1), 1'b1);
    send_sample({1'b1, {(SampleW-1){1'b0}}}, 1'b1);
    send_sample('1, 1'b1);
    write_window_length(LenW'(1));
    send_sample({1'b0, {(SampleW-1){1'b1}}}, 1'b1);
    send_sample('0, 1'b0);
  endtask

  task automatic test_short_wrap();
    write_window_length(LenW'(3));
    send_sample('0, 1'b1);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);
    send_sample({1'b1, {(SampleW-1){1'b0}}}, 1'b1);
    send_sample({1'b0, {(SampleW-1){1'b1}}}, 1'b1);
    send_sample(SampleW'(1), 1'b1);
    send_sample('1, 1'b0);
  endtask

  // Receiver holds off long enough that the block backs up into the input.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_window_length(LenW'(4));
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++)
      send_sample(pick_sample(), ($urandom_range(3) == 0));
  endtask

  // Length above the maximum saturates to 1024; a lone nonzero magnitude
  // among zeros gives a large crest, then random beats follow.
  task automatic test_full_window();
    logic [SampleW-1:0] s;
    logic               g;
    sender_idle_pct = 0;
    recv_stall_pct  = 26;
    write_window_length('1);
    for (int i = 0; i < FullItems; i++) begin
      if (i == 200)
        s = SampleW'($urandom_range(1, (1 << SampleW) - 1));
      else if (i < 240)
        s = '0;
      else
        s = pick_sample();
      if (i < 240)
        g = (i % 64 == 63) || (i == 199) || (i == 200);
      else
        g = 1'($urandom_range(1));
      send_sample(s, g);
    end
  endtask

  task automatic test_random_traffic();
    int               idle_mix [4] = '{0, 76, 0, 26};
    int               stall_mix [4] = '{0, 0, 76, 26};
    logic [LenW-1:0]  len;
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_mix[p];
      recv_stall_pct  = stall_mix[p];
      for (int k = 0; k < LensPerMix; k++) begin
        case ($urandom_range(9))
          0: len = '0;
          1: len = LenW'(1);
          2: len = '1;
          3: len = LenW'(LenReset);
          4: len = LenW'($urandom_range(MaxWin + 1, (1 << LenW) - 2));
          default: len = LenW'($urandom_range(2, 48));
        endcase
        write_window_length(len);
        for (int i = 0; i < RandItems; i++)
          send_sample(pick_sample(), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MaxWin; i++) mag_ring[i] = '0;
    wr_pos     = 0;
    ring_full  = 1'b0;
    held_crest = CrestOne;
    win_len_q  = LenW'(LenReset);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_length_extremes();
    test_short_wrap();
    test_backpressure();
    test_full_window();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (crest_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("windowed_crest_factor verification clean");
    else
      $display("windowed_crest_factor verification failed");
    $finish;
  end

endmodule
